// ===== rtl/ieba_pkg.sv =====
// Shared types and constants for the I2C EEPROM byte access master.
// No dependencies; imported by the top level.
`default_nettype none
package ieba_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACK_WAIT_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_WRITE_CYCLE_TICKS = 2'd1;

  // Register reset values
  localparam logic [7:0]  ACK_WAIT_LIMIT_RST    = 8'd255;
  localparam logic [15:0] WRITE_CYCLE_TICKS_RST = 16'd5000;

  // Device select bytes (block bits are OR'ed in at bits 3..1)
  localparam logic [7:0] DEV_SEL_WRITE = 8'hA0;
  localparam logic [7:0] DEV_SEL_READ  = 8'hA1;

  // Bits per byte on the bus
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Bus sequencer states
  typedef enum logic [16:0] {
    ST_IDLE      = 17'b00000000000000001,
    ST_START     = 17'b00000000000000010,
    ST_SEND_LOW  = 17'b00000000000000100,
    ST_SEND_HIGH = 17'b00000000000001000,
    ST_ACK_REL   = 17'b00000000000010000,
    ST_ACK       = 17'b00000000000100000,
    ST_RS_A      = 17'b00000000001000000,
    ST_RS_B      = 17'b00000000010000000,
    ST_RS_C      = 17'b00000000100000000,
    ST_RD_LOW    = 17'b00000001000000000,
    ST_RD_HIGH   = 17'b00000010000000000,
    ST_NACK_LOW  = 17'b00000100000000000,
    ST_NACK_HIGH = 17'b00001000000000000,
    ST_STOP_A    = 17'b00010000000000000,
    ST_STOP_B    = 17'b00100000000000000,
    ST_STOP_C    = 17'b01000000000000000,
    ST_WWAIT     = 17'b10000000000000000
  } phase_t;

  // Which byte is being sent
  typedef enum logic [1:0] {
    STG_DEVW = 2'd0,
    STG_ADDR = 2'd1,
    STG_DATA = 2'd2,
    STG_DEVR = 2'd3
  } stage_t;

endpackage
`default_nettype wire

// ===== rtl/i2c_eeprom_byte_access_master.sv =====
// I2C master for an 11-bit addressed EEPROM: byte write and random read.
// Depends on ieba_pkg for state types, command codes and constants.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   in       | sink      | in_valid / in_stall  | command, mem_addr, write_data, sda_in
//   out      | source    | out_valid / out_stall| scl, sda_release, busy_res,
//            |           |                      | done_res, read_data
//   cfg      | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each tick transfer is taken when in_valid is high and in_stall is low; its result is in the output
// register on the next cycle. One tick per cycle is sustained while out_stall is low, set by the
// single sequencer update between the state registers and the output register.
// Synchronous active-high rst clears the sequencer and counters and loads the config regs with their reset values.
// A new tick is taken while the output holds a result unless out_stall is high.
`default_nettype none
module i2c_eeprom_byte_access_master
  import ieba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // tick input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [10:0] mem_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic        sda_in,
  // bus result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl,
  output logic             sda_release,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       read_data,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic [7:0]  ack_wait_limit;
  logic [15:0] write_cycle_ticks;

  // Sequencer state
  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [10:0] held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic        is_read, is_read_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0]  last_read, last_read_next;

  // Result of this tick
  logic scl_next, sda_next, busy_next, done_next;

  logic   in_accept;
  logic   start_cmd;
  phase_t cur;
  logic   tx_bit;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Hold config registers; write on a config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit    <= ACK_WAIT_LIMIT_RST;
      write_cycle_ticks <= WRITE_CYCLE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACK_WAIT_LIMIT:    ack_wait_limit    <= cfg_data[7:0];
        CFG_WRITE_CYCLE_TICKS: write_cycle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a command only while idle; its own tick already drives START
  assign start_cmd = (phase == ST_IDLE) && ((command == CMD_WRITE) || (command == CMD_READ));
  assign cur       = start_cmd ? ST_START : phase;
  assign tx_bit    = shift_byte[7];

  // Sequencer: one tick of bus activity
  always_comb begin
    held_address_next = start_cmd ? mem_addr : held_address;
    held_data_next    = start_cmd ? write_data : held_data;
    is_read_next      = start_cmd ? (command == CMD_READ) : is_read;
    phase_next        = cur;
    stage_next        = stage;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    wait_count_next   = wait_count;
    last_read_next    = last_read;
    scl_next          = 1'b1;
    sda_next          = 1'b1;
    busy_next         = 1'b1;
    done_next         = 1'b0;

    unique case (cur)
      ST_START: begin
        sda_next        = 1'b0;
        shift_byte_next = DEV_SEL_WRITE | {4'b0, held_address_next[10:8], 1'b0};
        bit_count_next  = 4'd0;
        stage_next      = STG_DEVW;
        phase_next      = ST_SEND_LOW;
      end
      ST_SEND_LOW: begin
        scl_next   = 1'b0;
        sda_next   = tx_bit;
        phase_next = ST_SEND_HIGH;
      end
      ST_SEND_HIGH: begin
        sda_next        = tx_bit;
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_count + 4'd1;
        phase_next      = (bit_count_next >= BITS_PER_BYTE) ? ST_ACK_REL : ST_SEND_LOW;
      end
      ST_ACK_REL: begin
        scl_next        = 1'b0;
        wait_count_next = '0;
        phase_next      = ST_ACK;
      end
      ST_ACK: begin
        // stretch the ack clock until SDA low or the wait limit runs out
        if (sda_in && (wait_count < {8'b0, ack_wait_limit})) begin
          wait_count_next = wait_count + 16'd1;
        end else begin
          wait_count_next = '0;
          unique case (stage)
            STG_DEVW: begin
              shift_byte_next = held_address[7:0];
              bit_count_next  = 4'd0;
              stage_next      = STG_ADDR;
              phase_next      = ST_SEND_LOW;
            end
            STG_ADDR: begin
              if (is_read) begin
                phase_next = ST_RS_A;
              end else begin
                shift_byte_next = held_data;
                bit_count_next  = 4'd0;
                stage_next      = STG_DATA;
                phase_next      = ST_SEND_LOW;
              end
            end
            STG_DATA: phase_next = ST_STOP_A;
            default: begin
              shift_byte_next = '0;
              bit_count_next  = 4'd0;
              phase_next      = ST_RD_LOW;
            end
          endcase
        end
      end
      ST_RS_A: begin
        scl_next   = 1'b0;
        phase_next = ST_RS_B;
      end
      ST_RS_B: phase_next = ST_RS_C;
      ST_RS_C: begin
        sda_next        = 1'b0;
        shift_byte_next = DEV_SEL_READ | {4'b0, held_address[10:8], 1'b0};
        bit_count_next  = 4'd0;
        stage_next      = STG_DEVR;
        phase_next      = ST_SEND_LOW;
      end
      ST_RD_LOW: begin
        scl_next   = 1'b0;
        phase_next = ST_RD_HIGH;
      end
      ST_RD_HIGH: begin
        shift_byte_next = {shift_byte[6:0], sda_in};
        bit_count_next  = bit_count + 4'd1;
        if (bit_count_next >= BITS_PER_BYTE) begin
          last_read_next = shift_byte_next;
          phase_next     = ST_NACK_LOW;
        end else begin
          phase_next = ST_RD_LOW;
        end
      end
      ST_NACK_LOW: begin
        scl_next   = 1'b0;
        phase_next = ST_NACK_HIGH;
      end
      ST_NACK_HIGH: phase_next = ST_STOP_A;
      ST_STOP_A: begin
        scl_next   = 1'b0;
        sda_next   = 1'b0;
        phase_next = ST_STOP_B;
      end
      ST_STOP_B: begin
        sda_next   = 1'b0;
        phase_next = ST_STOP_C;
      end
      ST_STOP_C: begin
        if (is_read) begin
          busy_next  = 1'b0;
          done_next  = 1'b1;
          phase_next = ST_IDLE;
        end else begin
          wait_count_next = write_cycle_ticks;
          phase_next      = ST_WWAIT;
        end
      end
      ST_WWAIT: begin
        // count down the EEPROM write time
        if (wait_count == '0) begin
          busy_next  = 1'b0;
          done_next  = 1'b1;
          phase_next = ST_IDLE;
        end else begin
          wait_count_next = wait_count - 16'd1;
        end
      end
      default: begin
        busy_next  = 1'b0;
        phase_next = ST_IDLE;
      end
    endcase
  end

  // Advance the sequencer on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ST_IDLE;
      stage        <= STG_DEVW;
      bit_count    <= '0;
      shift_byte   <= '0;
      held_address <= '0;
      held_data    <= '0;
      is_read      <= 1'b0;
      wait_count   <= '0;
      last_read    <= '0;
    end else if (in_accept) begin
      phase        <= phase_next;
      stage        <= stage_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      held_address <= held_address_next;
      held_data    <= held_data_next;
      is_read      <= is_read_next;
      wait_count   <= wait_count_next;
      last_read    <= last_read_next;
    end
  end

  // Output register: load on accept, drop valid once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      scl         <= scl_next;
      sda_release <= sda_next;
      busy_res    <= busy_next;
      done_res    <= done_next;
      read_data   <= last_read_next;
    end
  end

  // Checks on the sequencer and output register
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("done and busy reported on the same tick");

  a_accept_fills_out: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted tick produced no result");

  a_start_enters_devw: assert property (@(posedge clk) disable iff (rst)
    (in_accept && start_cmd) |=> (phase == ST_SEND_LOW && stage == STG_DEVW))
    else $error("start command did not begin the device byte");

  a_byte_ends_in_ack: assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == ST_SEND_HIGH && bit_count == 4'd7) |=> (phase == ST_ACK_REL))
    else $error("eighth bit did not lead to the acknowledge clock");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(phase) && $stable(wait_count))
    else $error("sequencer moved without an accepted tick");

endmodule
`default_nettype wire
